// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated: next-cycle implication");

`endif

// ===== rtl/rotpiv_pkg.sv =====
// constants and types for the pivot rotation pipeline
// no dependencies
package rotpiv_pkg;

    localparam int GUARD_BITS  = 8;
    localparam int ANGLE_WIDTH = 18;
    localparam int ANGLE_SHIFT = 16;
    localparam int ZW          = 32;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [ZW-1:0]          zangle_t;

    // degrees with 8 fraction bits
    localparam angle_t DEG_HALF_TURN    = 18'sd46080;
    localparam angle_t DEG_QUARTER_TURN = 18'sd23040;
    localparam angle_t DEG_FULL_TURN    = 18'sd92160;

    // quarter turn in cordic angle units (2^-24 degree)
    localparam zangle_t QUARTER_Z = 32'sd1509949440;

    // 1/K in q0.32
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    // atan(2^-i) in units of 2^-24 degree
    localparam zangle_t ATAN_TABLE [32] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

endpackage

// ===== rtl/rotate_point_about_pivot.sv =====
// stages: offset, quarter turn, cordic iterations, abs, multiply, sum, output
// throughput: one item per cycle unless the output stalls; every cordic iteration
// has its own register stage; the gain multiply is split into two partial products
// stalls: each stage takes a new item when it is empty or its successor moves on
// reset: rst_n clears the stage valid bits only; the datapath registers are not reset
// depends on rotpiv_pkg and assert_macros.svh
module rotate_point_about_pivot #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // input item: point_x, point_y, pivot_x, pivot_y, angle_deg (lowest bits first),
    // zero padded to whole bytes
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((4*COORD_WIDTH+rotpiv_pkg::ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // result item: rotated_x, rotated_y (lowest bits first), zero padded to whole bytes
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);
    import rotpiv_pkg::*;

    `include "assert_macros.svh"

    // datapath widths: offsets carry guard bits plus headroom for cordic gain
    localparam int W            = COORD_WIDTH + GUARD_BITS + 3;
    localparam int HI_W         = (W > 32) ? W - 32 : 1;
    localparam int RW           = W - GUARD_BITS;
    localparam int SUM_W        = RW + 1;
    localparam int OUT_TDATA_W  = ((2*COORD_WIDTH + 7) / 8) * 8;

    // stage map
    localparam int ST_QUAD = 1;
    localparam int ST_ABS  = CORDIC_STEPS + 2;
    localparam int ST_MUL  = CORDIC_STEPS + 3;
    localparam int ST_SUM  = CORDIC_STEPS + 4;
    localparam int LAST    = CORDIC_STEPS + 5;

    // input fields
    logic signed [COORD_WIDTH-1:0] in_px, in_py, in_cx, in_cy;
    angle_t                        in_ang;

    assign in_px  = s_tdata[0             +: COORD_WIDTH];
    assign in_py  = s_tdata[COORD_WIDTH   +: COORD_WIDTH];
    assign in_cx  = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign in_cy  = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign in_ang = s_tdata[4*COORD_WIDTH +: ANGLE_WIDTH];

    // per-stage valid bits and the ready chain that lets bubbles collapse
    logic [LAST:0]   valid_reg;
    logic [LAST+1:0] stage_ready;

    assign stage_ready[LAST+1] = m_tready;

    for (genvar k = 0; k <= LAST; k++)
    begin : g_ready
        assign stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // pivot travels beside the item up to the final add
    logic signed [COORD_WIDTH-1:0] pvx_reg [0:ST_SUM];
    logic signed [COORD_WIDTH-1:0] pvy_reg [0:ST_SUM];

    for (genvar k = 0; k <= ST_SUM; k++)
    begin : g_pivot
        if (k == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (stage_ready[0])
                begin
                    pvx_reg[0] <= in_cx;
                    pvy_reg[0] <= in_cy;
                end
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk)
            begin
                if (stage_ready[k])
                begin
                    pvx_reg[k] <= pvx_reg[k-1];
                    pvy_reg[k] <= pvy_reg[k-1];
                end
            end
        end
    end

    // stage 0: exact offsets and angle wrapped into (-180, 180]
    logic signed [COORD_WIDTH:0] dx_reg, dy_reg;
    angle_t                      ang_reg;
    angle_t                      ang_next;

    always_comb
    begin
        if (in_ang > DEG_HALF_TURN)
        begin
            ang_next = in_ang - DEG_FULL_TURN;
        end
        else if (in_ang <= -DEG_HALF_TURN)
        begin
            ang_next = in_ang + DEG_FULL_TURN;
        end
        else
        begin
            ang_next = in_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            dx_reg  <= {in_px[COORD_WIDTH-1], in_px} - {in_cx[COORD_WIDTH-1], in_cx};
            dy_reg  <= {in_py[COORD_WIDTH-1], in_py} - {in_cy[COORD_WIDTH-1], in_cy};
            ang_reg <= ang_next;
        end
    end

    // stage 1: exact quarter turn so the cordic sees [-90, 90] degrees
    // x_reg/y_reg/z_reg index j holds the vector after j cordic iterations
    logic signed [W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [W-1:0] y_reg [0:CORDIC_STEPS];
    zangle_t             z_reg [0:CORDIC_STEPS];

    logic signed [W-1:0] xw, yw, xq_next, yq_next;
    angle_t              aq;

    assign xw = {{(W-COORD_WIDTH-1-GUARD_BITS){dx_reg[COORD_WIDTH]}}, dx_reg,
                 {GUARD_BITS{1'b0}}};
    assign yw = {{(W-COORD_WIDTH-1-GUARD_BITS){dy_reg[COORD_WIDTH]}}, dy_reg,
                 {GUARD_BITS{1'b0}}};

    always_comb
    begin
        if (ang_reg > DEG_QUARTER_TURN)
        begin
            xq_next = -yw;
            yq_next = xw;
            aq      = ang_reg - DEG_QUARTER_TURN;
        end
        else if (ang_reg < -DEG_QUARTER_TURN)
        begin
            xq_next = yw;
            yq_next = -xw;
            aq      = ang_reg + DEG_QUARTER_TURN;
        end
        else
        begin
            xq_next = xw;
            yq_next = yw;
            aq      = ang_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[ST_QUAD])
        begin
            x_reg[0] <= xq_next;
            y_reg[0] <= yq_next;
            z_reg[0] <= zangle_t'(aq) <<< ANGLE_SHIFT;
        end
    end

    // cordic: one register stage per iteration, direction from the residual sign
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [W-1:0] xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (stage_ready[ST_QUAD+1+i])
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TABLE[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TABLE[i];
                end
            end
        end
    end

    // magnitude and sign ahead of the gain multiply
    logic [W-1:0] mag_x_reg, mag_y_reg;
    logic         neg_x_reg, neg_y_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[ST_ABS])
        begin
            neg_x_reg <= x_reg[CORDIC_STEPS][W-1];
            neg_y_reg <= y_reg[CORDIC_STEPS][W-1];
            mag_x_reg <= x_reg[CORDIC_STEPS][W-1] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            mag_y_reg <= y_reg[CORDIC_STEPS][W-1] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    // gain removal: magnitude split at bit 32, two partial products by 1/K
    logic [63:0]        mx64, my64, lo_prod_x, lo_prod_y;
    logic [HI_W+31:0]   hi_prod_x_reg, hi_prod_y_reg;
    logic [31:0]        lo_up_x_reg, lo_up_y_reg;
    logic               neg_x_mul_reg, neg_y_mul_reg;

    assign mx64      = 64'(mag_x_reg);
    assign my64      = 64'(mag_y_reg);
    assign lo_prod_x = 64'(mx64[31:0]) * 64'(INV_GAIN_Q32);
    assign lo_prod_y = 64'(my64[31:0]) * 64'(INV_GAIN_Q32);

    always_ff @(posedge clk)
    begin
        if (stage_ready[ST_MUL])
        begin
            hi_prod_x_reg <= (HI_W+32)'(mx64[32 +: HI_W]) * (HI_W+32)'(INV_GAIN_Q32);
            hi_prod_y_reg <= (HI_W+32)'(my64[32 +: HI_W]) * (HI_W+32)'(INV_GAIN_Q32);
            lo_up_x_reg   <= lo_prod_x[63:32];
            lo_up_y_reg   <= lo_prod_y[63:32];
            neg_x_mul_reg <= neg_x_reg;
            neg_y_mul_reg <= neg_y_reg;
        end
    end

    // combine partial products, drop guard bits rounding half up, restore sign
    logic [W:0]           rnd_x, rnd_y;
    logic signed [RW-1:0] res_x_reg, res_y_reg;

    assign rnd_x = ((W+1)'(hi_prod_x_reg) + (W+1)'(lo_up_x_reg)
                    + (W+1)'(1 << (GUARD_BITS-1))) >> GUARD_BITS;
    assign rnd_y = ((W+1)'(hi_prod_y_reg) + (W+1)'(lo_up_y_reg)
                    + (W+1)'(1 << (GUARD_BITS-1))) >> GUARD_BITS;

    always_ff @(posedge clk)
    begin
        if (stage_ready[ST_SUM])
        begin
            res_x_reg <= neg_x_mul_reg ? -signed'(rnd_x[RW-1:0]) : signed'(rnd_x[RW-1:0]);
            res_y_reg <= neg_y_mul_reg ? -signed'(rnd_y[RW-1:0]) : signed'(rnd_y[RW-1:0]);
        end
    end

    // add the pivot back and saturate to the coordinate range
    logic signed [SUM_W-1:0]       sum_x, sum_y;
    logic signed [COORD_WIDTH-1:0] rot_x_next, rot_y_next, rot_x_reg, rot_y_reg;

    assign sum_x = SUM_W'(res_x_reg) + SUM_W'(pvx_reg[ST_SUM]);
    assign sum_y = SUM_W'(res_y_reg) + SUM_W'(pvy_reg[ST_SUM]);

    always_comb
    begin
        if (sum_x[SUM_W-1:COORD_WIDTH-1] == {(SUM_W-COORD_WIDTH+1){sum_x[SUM_W-1]}})
        begin
            rot_x_next = sum_x[COORD_WIDTH-1:0];
        end
        else
        begin
            rot_x_next = {sum_x[SUM_W-1], {(COORD_WIDTH-1){~sum_x[SUM_W-1]}}};
        end
        if (sum_y[SUM_W-1:COORD_WIDTH-1] == {(SUM_W-COORD_WIDTH+1){sum_y[SUM_W-1]}})
        begin
            rot_y_next = sum_y[COORD_WIDTH-1:0];
        end
        else
        begin
            rot_y_next = {sum_y[SUM_W-1], {(COORD_WIDTH-1){~sum_y[SUM_W-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[LAST])
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
        end
    end

    assign m_tdata = OUT_TDATA_W'({rot_y_reg, rot_x_reg});

    // an accepted item always lands in the first stage
    `ASSERT_NEXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, valid_reg[0])
    // while any stage is empty the input side must be open
    `ASSERT_IMPL(a_no_false_stall, clk, rst_n, !(&valid_reg), s_tready)
    // wrapped angle stays within (-180, 180] degrees
    `ASSERT_IMPL(a_angle_wrapped, clk, rst_n, valid_reg[0],
                 (ang_reg <= DEG_HALF_TURN) && (ang_reg > -DEG_HALF_TURN))
    // cordic start angle stays within [-90, 90] degrees
    `ASSERT_IMPL(a_angle_quarter, clk, rst_n, valid_reg[ST_QUAD],
                 (z_reg[0] <= QUARTER_Z) && (z_reg[0] >= -QUARTER_Z))

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for rotate_point_about_pivot: a stream of points, pivots and
// angles goes in, every rotated result is checked against a bit-exact cordic predictor
// depends on rotpiv_pkg and the rotate_point_about_pivot rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rotpiv_pkg::*;

    localparam int COORD_W   = 32;
    localparam int STEPS     = 16;
    localparam int GUARD     = 8;
    localparam int LATENCY   = STEPS + 5;
    localparam int IN_W      = ((4*COORD_W + rotpiv_pkg::ANGLE_WIDTH + 7)/8)*8;
    localparam int OUT_W     = ((2*COORD_W + 7)/8)*8;
    localparam int CYCLE_CAP = 200000;

    // angle units: degrees with 8 fraction bits
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam int FULL_TURN    = 92160;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE       = 32'sh00010000;

    // 1/K in q0.32, the cordic gain correction
    localparam logic [63:0] INV_GAIN = 64'h0000_0000_9B74_EDA8;

    // atan(2^-i) in 2^-24 degree
    localparam longint ARCTAN [32] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934,  30029717,  15018523,  7509720,
        3754917,   1877466,   938734,    469367,
        234684,    117342,    58671,     29335,
        14668,     7334,      3667,      1833,
        917,       458,       229,       115,
        57,        29,        14,        7,
        4,         2,         1,         0
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } rotated_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;    // point_x, point_y, pivot_x, pivot_y, angle_deg
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;    // rotated_x, rotated_y

    rotated_t pending_rotations[$];
    int       mismatch_count = 0;
    int       checked_count  = 0;
    int       sent_count     = 0;
    int       cycle_count    = 0;
    bit       tx_idle_on     = 1'b1;
    bit       rx_idle_on     = 1'b1;
    int       rx_stall_left  = 0;

    rotate_point_about_pivot #(
        .COORD_WIDTH  (COORD_W),
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------

    // magnitude times 1/K, floored to guard units, then rounded half up to q16.16;
    // sign restored afterwards so ties go away from zero
    function automatic longint drop_gain(input longint v);
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] prod;
        logic [63:0] rounded;
        mag     = (v < 0) ? 64'(-v) : 64'(v);
        hi      = mag >> 32;
        lo      = mag & 64'hFFFF_FFFF;
        prod    = hi * INV_GAIN + ((lo * INV_GAIN) >> 32);
        rounded = (prod + (64'd1 << (GUARD - 1))) >> GUARD;
        return (v < 0) ? -longint'(rounded) : longint'(rounded);
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return v[31:0];
    endfunction

    function automatic rotated_t predict_rotation(
        input logic signed [31:0] px,
        input logic signed [31:0] py,
        input logic signed [31:0] cx,
        input logic signed [31:0] cy,
        input angle_t             ang
    );
        longint   x;
        longint   y;
        longint   z;
        longint   xs;
        longint   ys;
        longint   tmp;
        int       a;
        rotated_t res;
        // offsets carry guard bits through the iterations
        x = (longint'(px) - longint'(cx)) * (64'sd1 << GUARD);
        y = (longint'(py) - longint'(cy)) * (64'sd1 << GUARD);
        a = int'(ang);
        // fold into (-180, 180]
        while (a > HALF_TURN)
            a -= FULL_TURN;
        while (a <= -HALF_TURN)
            a += FULL_TURN;
        // exact quarter turn so the iterations only see [-90, 90]
        if (a > QUARTER_TURN)
        begin
            tmp = x;
            x   = -y;
            y   = tmp;
            a  -= QUARTER_TURN;
        end
        else if (a < -QUARTER_TURN)
        begin
            tmp = x;
            x   = y;
            y   = -tmp;
            a  += QUARTER_TURN;
        end
        z = longint'(a) * 65536;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end
        end
        res.x = clamp_coord(drop_gain(x) + longint'(cx));
        res.y = clamp_coord(drop_gain(y) + longint'(cy));
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // result side: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        rotated_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rotations.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (m_tdata[31:0] !== want.x)
                    report_mismatch("rotated_x", m_tdata[31:0], want.x);
                if (m_tdata[63:32] !== want.y)
                    report_mismatch("rotated_y", m_tdata[63:32], want.y);
                checked_count++;
            end
        end
    end

    // result side back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rotations.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------------

    // after an optional random idle gap, drives one item, holds it until accepted, then
    // records its prediction; called right after a rising edge
    task automatic send_point(
        input logic signed [31:0] px,
        input logic signed [31:0] py,
        input logic signed [31:0] cx,
        input logic signed [31:0] cy,
        input angle_t             ang
    );
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, cy, cx, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        pending_rotations.push_back(predict_rotation(px, py, cx, cy, ang));
        sent_count++;
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return 32'sd0;
                    3:       return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $urandom;
            // typical geometry: within about +-64 units
            default: return int'($urandom_range(0, 8388608)) - 4194304;
        endcase
    endfunction

    function automatic angle_t pick_angle();
        if ($urandom_range(0, 15) == 0)
            return angle_t'($urandom);  // anything the 18 bits can hold
        return angle_t'(int'($urandom_range(0, 2*FULL_TURN)) - FULL_TURN);
    endfunction

    // corners of the coordinate range, zero offset and saturation both ways
    task automatic test_coordinate_extremes();
        send_point(32'sd0, 32'sd0, 32'sd0, 32'sd0, angle_t'(0));
        send_point(ONE, 32'sd0, 32'sd0, 32'sd0, angle_t'(90*256));
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, angle_t'(12345));
        send_point(COORD_MAX, 32'sd0, COORD_MIN, 32'sd0, angle_t'(0));
        send_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, angle_t'(180*256));
        send_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, angle_t'(180*256));
        send_point(COORD_MIN, COORD_MAX, 32'sd0, 32'sd0, angle_t'(-90*256));
        send_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, angle_t'(45*256));
    endtask

    // quarter-turn and half-turn boundaries, the full-turn wrap and angles past 360
    task automatic test_angle_folding();
        int folds [15] = '{
            QUARTER_TURN, QUARTER_TURN + 1, -QUARTER_TURN, -QUARTER_TURN - 1,
            HALF_TURN, -HALF_TURN, HALF_TURN - 1, FULL_TURN, -FULL_TURN,
            131071, -131072, 100000, -100000, 1, -1
        };
        foreach (folds[i])
            send_point(32'sh0003_8000, -32'sh0002_4000, ONE, ONE, angle_t'(folds[i]));
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_angle());
    endtask

    // ---------------------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coordinate_extremes();
        test_angle_folding();
        test_random_mix(450);

        // last stretch: full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_mix(150);
        s_tvalid <= 1'b0;

        while (pending_rotations.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("rotated %0d points (%0d checked): range corners, saturation, angle folds,",
                 sent_count, checked_count);
        $display("random coordinates and angles with and without stalls, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_rotations.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
